// ----- sv/kvls_pkg.sv -----
`timescale 1ns / 1ps

package kvls_pkg;

    // Buffer and key limits
    localparam int unsigned MAX_BUFFER_BYTES = 65536;
    localparam int unsigned MAX_KEY_BYTES    = 32;
    localparam int unsigned POS_CAP          = 65536;
    localparam logic [16:0] BUF_LIMIT        =
        17'(MAX_BUFFER_BYTES < POS_CAP ? MAX_BUFFER_BYTES : POS_CAP);
    localparam logic [5:0]  KEY_LEN_CAP      = 6'(MAX_KEY_BYTES);

    // Byte codes
    localparam logic [7:0] BYTE_NL  = 8'h0A;
    localparam logic [7:0] BYTE_EQ  = 8'h3D;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3   = 3'd4;

    // Record kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Queue between scanner and output stage
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // One result record
    typedef struct packed {
        logic        kind;
        logic [15:0] key_offset;
        logic [15:0] key_length;
        logic [16:0] value_offset;
        logic [15:0] value_length;
        logic        key_matches;
        logic [15:0] entry_count;
        logic        buffer_valid;
    } rec_t;

    // All results caused by one item
    typedef struct packed {
        logic has_entry;
        logic has_summary;
        rec_t entry;
        rec_t summary;
    } slot_t;

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

endpackage

// ----- sv/key_value_line_scanner.sv -----
`timescale 1ns / 1ps

// An item's first result reaches the output ports through the queue write, then the output
// register load. Throughput: one item per cycle while the queue is not full; an item that
// closes a line and the buffer yields two results, which leave over two pops. The four-slot
// queue plus the output register hold the results of up to five items before full stalls
// the input.
// Reset: rst_n clears scan state, queue, output register and search key registers at once.
module key_value_line_scanner (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     data_byte,
    input  logic                           byte_present,
    input  logic                           end_of_buffer,
    output logic                           empty,
    input  logic                           pop,
    output logic                           record_kind,
    output logic [15:0]                    key_offset,
    output logic [15:0]                    key_length,
    output logic [16:0]                    value_offset,
    output logic [15:0]                    value_length,
    output logic                           key_matches,
    output logic [15:0]                    entry_count,
    output logic                           buffer_valid,
    output logic                           last_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kvls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);

    logic            wr_en;
    kvls_pkg::slot_t wr_slot;
    logic            rd_en;
    kvls_pkg::slot_t rd_slot;
    logic            q_full;
    logic            q_empty;
    kvls_pkg::rec_t  head;

    assign full      = q_full;
    assign cfg_ready = 1'b1;

    kvls_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .data_byte     (data_byte),
        .byte_present  (byte_present),
        .end_of_buffer (end_of_buffer),
        .q_full        (q_full),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .wr_en         (wr_en),
        .wr_slot       (wr_slot)
    );

    kvls_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .rd_en   (rd_en),
        .rd_slot (rd_slot),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    kvls_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_slot (rd_slot),
        .q_empty (q_empty),
        .rd_en   (rd_en),
        .pop     (pop),
        .empty   (empty),
        .head    (head)
    );

    // Drive result ports from the output register
    assign record_kind  = head.kind;
    assign key_offset   = head.key_offset;
    assign key_length   = head.key_length;
    assign value_offset = head.value_offset;
    assign value_length = head.value_length;
    assign key_matches  = head.key_matches;
    assign entry_count  = head.entry_count;
    assign buffer_valid = head.buffer_valid;
    assign last_result  = head.kind;

endmodule

// ----- sv/kvls_front.sv -----
`timescale 1ns / 1ps

module kvls_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [7:0]                        data_byte,
    input  logic                              byte_present,
    input  logic                              end_of_buffer,
    input  logic                              q_full,
    input  logic                              cfg_valid,
    input  logic [kvls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data,
    output logic                              wr_en,
    output kvls_pkg::slot_t                   wr_slot
);

    typedef struct packed {
        logic [16:0] bpos;
        logic        in_line;
        logic [15:0] key_start;
        logic        sep_seen;
        logic [15:0] sep_off;
        logic [5:0]  kci;
        logic        kse;
        logic        lkm;
        logic        nul;
        logic [15:0] entries;
        logic        match_found;
        logic [16:0] mvo;
        logic [15:0] mvl;
        logic        fok;
    } scan_t;

    localparam scan_t SCAN_RESET = '{
        bpos: 17'd0, in_line: 1'b0, key_start: 16'd0, sep_seen: 1'b0,
        sep_off: 16'd0, kci: 6'd0, kse: 1'b1, lkm: 1'b0, nul: 1'b0,
        entries: 16'd0, match_found: 1'b0, mvo: 17'd0, mvl: 16'd0, fok: 1'b1
    };

    scan_t          st_reg;
    scan_t          st_next;
    scan_t          s;
    logic [5:0]     key_len_reg;
    logic [255:0]   key_reg;
    logic [5:0]     eff_len;
    logic [7:0]     kbyte;
    logic [16:0]    p;
    logic [16:0]    endpos;
    logic [15:0]    kl;
    logic [16:0]    vo;
    logic [15:0]    vl;
    logic           is_nl;
    logic           do_close;
    logic           acc;
    kvls_pkg::slot_t slot;

    assign acc     = push && !q_full;
    assign eff_len = (key_len_reg > kvls_pkg::KEY_LEN_CAP) ? kvls_pkg::KEY_LEN_CAP
                                                           : key_len_reg;

    // Hold search key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= '0;
            key_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                kvls_pkg::REG_KEY_LEN: key_len_reg      <= cfg_data[5:0];
                kvls_pkg::REG_KEY_0:   key_reg[63:0]    <= cfg_data;
                kvls_pkg::REG_KEY_1:   key_reg[127:64]  <= cfg_data;
                kvls_pkg::REG_KEY_2:   key_reg[191:128] <= cfg_data;
                kvls_pkg::REG_KEY_3:   key_reg[255:192] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Scan one item: update line state, then close the line if it ends here
    always_comb
    begin
        s      = st_reg;
        slot   = '0;
        p      = st_reg.bpos;
        is_nl  = byte_present && (data_byte == kvls_pkg::BYTE_NL);
        kbyte  = key_reg[{st_reg.kci[4:0], 3'b000} +: 8];
        kl     = '0;
        vo     = '0;
        vl     = '0;

        if (byte_present)
        begin
            if (p >= kvls_pkg::BUF_LIMIT)
                s.fok = 1'b0;
            if (!is_nl)
            begin
                if (!s.in_line)
                begin
                    s.in_line   = 1'b1;
                    s.key_start = kvls_pkg::sat16(p);
                end
                if (data_byte == kvls_pkg::BYTE_NUL)
                    s.nul = 1'b1;
                if (!s.sep_seen)
                begin
                    if (data_byte == kvls_pkg::BYTE_EQ)
                    begin
                        s.sep_seen = 1'b1;
                        s.sep_off  = kvls_pkg::sat16(p);
                        if (kvls_pkg::sat16(p) == s.key_start)
                            s.fok = 1'b0;
                        s.lkm = s.kse && (s.kci == eff_len);
                    end
                    else if ((s.kci < eff_len) && (data_byte == kbyte))
                        s.kci = s.kci + 6'd1;
                    else
                        s.kse = 1'b0;
                end
            end
            if (!p[16])
                s.bpos = p + 17'd1;
        end

        do_close = is_nl || end_of_buffer;
        endpos   = is_nl ? p : s.bpos;

        // Close the open line
        if (do_close)
        begin
            if (s.in_line)
            begin
                if (s.nul || !s.sep_seen)
                    s.fok = 1'b0;
                if (s.sep_seen)
                begin
                    kl = (s.sep_off >= s.key_start) ? (s.sep_off - s.key_start) : 16'd0;
                    vo = {1'b0, s.sep_off} + 17'd1;
                    vl = (endpos > vo) ? 16'(endpos - vo) : 16'd0;
                    if (s.entries != 16'hFFFF)
                        s.entries = s.entries + 16'd1;
                    if (s.lkm && !s.match_found)
                    begin
                        s.match_found = 1'b1;
                        s.mvo         = vo;
                        s.mvl         = vl;
                    end
                    slot.has_entry          = 1'b1;
                    slot.entry.kind         = kvls_pkg::KIND_ENTRY;
                    slot.entry.key_offset   = s.key_start;
                    slot.entry.key_length   = kl;
                    slot.entry.value_offset = vo;
                    slot.entry.value_length = vl;
                    slot.entry.key_matches  = s.lkm;
                    slot.entry.entry_count  = s.entries;
                    slot.entry.buffer_valid = 1'b0;
                end
            end
            s.in_line  = 1'b0;
            s.sep_seen = 1'b0;
            s.sep_off  = '0;
            s.kci      = '0;
            s.kse      = 1'b1;
            s.lkm      = 1'b0;
            s.nul      = 1'b0;
        end

        // Emit the summary and start a fresh buffer
        if (end_of_buffer)
        begin
            slot.has_summary          = 1'b1;
            slot.summary.kind         = kvls_pkg::KIND_SUMMARY;
            slot.summary.key_offset   = '0;
            slot.summary.key_length   = '0;
            slot.summary.value_offset = s.match_found ? s.mvo : 17'd0;
            slot.summary.value_length = s.match_found ? s.mvl : 16'd0;
            slot.summary.key_matches  = s.match_found;
            slot.summary.entry_count  = s.entries;
            slot.summary.buffer_valid = s.fok;
            s = SCAN_RESET;
        end

        st_next = acc ? s : st_reg;
        wr_en   = acc && (slot.has_entry || slot.has_summary);
        wr_slot = slot;
    end

    // Advance scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= SCAN_RESET;
        else
            st_reg <= st_next;
    end

    // A summary is produced only by the closing item of a buffer
    a_summary_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && wr_slot.has_summary |-> end_of_buffer)
        else $error("summary produced without end of buffer");

endmodule

// ----- sv/kvls_queue.sv -----
`timescale 1ns / 1ps

module kvls_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  kvls_pkg::slot_t wr_slot,
    input  logic            rd_en,
    output kvls_pkg::slot_t rd_slot,
    output logic            q_full,
    output logic            q_empty
);

    kvls_pkg::slot_t                 mem_reg [kvls_pkg::Q_DEPTH];
    logic [kvls_pkg::Q_AW-1:0]       wr_ptr_reg;
    logic [kvls_pkg::Q_AW-1:0]       wr_ptr_next;
    logic [kvls_pkg::Q_AW-1:0]       rd_ptr_reg;
    logic [kvls_pkg::Q_AW-1:0]       rd_ptr_next;
    logic [kvls_pkg::Q_CW-1:0]       count_reg;
    logic [kvls_pkg::Q_CW-1:0]       count_next;

    assign q_full  = (count_reg == kvls_pkg::Q_CW'(kvls_pkg::Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_slot = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store slots
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_slot;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("read from empty queue");

endmodule

// ----- sv/kvls_back.sv -----
`timescale 1ns / 1ps

module kvls_back (
    input  logic            clk,
    input  logic            rst_n,
    input  kvls_pkg::slot_t rd_slot,
    input  logic            q_empty,
    output logic            rd_en,
    input  logic            pop,
    output logic            empty,
    output kvls_pkg::rec_t  head
);

    kvls_pkg::slot_t cur_reg;
    kvls_pkg::slot_t cur_next;
    logic            pop_acc;

    assign empty   = !(cur_reg.has_entry || cur_reg.has_summary);
    assign pop_acc = pop && !empty;
    assign head    = cur_reg.has_entry ? cur_reg.entry : cur_reg.summary;

    // Drop the delivered record, then refill from the queue when drained
    always_comb
    begin
        cur_next = cur_reg;
        if (pop_acc)
        begin
            if (cur_reg.has_entry)
                cur_next.has_entry = 1'b0;
            else
                cur_next.has_summary = 1'b0;
        end
        rd_en = !(cur_next.has_entry || cur_next.has_summary) && !q_empty;
        if (rd_en)
            cur_next = rd_slot;
    end

    // Hold the records on offer at the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else
            cur_reg <= cur_next;
    end

    // The summary follows its entry record in the next slot of the output
    a_summary_after_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop_acc && cur_reg.has_entry && cur_reg.has_summary |=> !empty && head.kind)
        else $error("summary lost after entry record");

endmodule
